/* hdl/swss_pkg.sv */
// Shared constants, types and codes for the sensor window statistics block.
// No dependencies; every other file imports this package.
package swss_pkg;

   localparam int MAX_COUNT    = 128;
   localparam int SAMPLE_WIDTH = 12;
   localparam int LIMIT_W      = 12;
   localparam int SUM_W        = 20;
   localparam int AVG_W        = 20;
   localparam int FRAC_BITS    = 8;
   localparam int DIVD_W       = SUM_W + FRAC_BITS;
   localparam int CNT_W        = $clog2(MAX_COUNT + 1);
   localparam int OUT_CNT_W    = 8;
   localparam int SPIKE_W      = 12;
   localparam int STATUS_W     = 2;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 12;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ITER_W       = $clog2(DIVD_W);

   localparam logic [LIMIT_W-1:0] STABLE_LIMIT_RESET   = 12'd3;
   localparam logic [LIMIT_W-1:0] CRITICAL_LIMIT_RESET = 12'd7;

   localparam logic [CSR_IDX_W-1:0] REG_STABLE_LIMIT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CRITICAL_LIMIT = 1'd1;

   localparam logic [STATUS_W-1:0] STATUS_STABLE   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_WARNING  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CRITICAL = 2'd2;

   // finished window, handed from front to back
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] max_reading;
      logic signed [SAMPLE_WIDTH-1:0] min_reading;
      logic signed [SUM_W-1:0]        sum;
      logic [SPIKE_W-1:0]             spike;
      logic [CNT_W-1:0]               count;
      logic                           overflow;
   } swss_rec_type;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_DIV  = 3'b010,
      B_DONE = 3'b100
   } swss_back_state_type;

endpackage

/* hdl/swss_req_if.sv */
// Sample channel: valid/ready handshake with one sensor word.
// Depends on swss_pkg.
interface swss_req_if;
   import swss_pkg::*;
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           last_sample;
   modport source(output valid, sample, last_sample, input ready);
   modport sink(input valid, sample, last_sample, output ready);
endinterface

/* hdl/swss_rsp_if.sv */
// Report channel: valid/ready handshake with one window report word.
// Depends on swss_pkg.
interface swss_rsp_if;
   import swss_pkg::*;
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] max_reading;
   logic signed [SAMPLE_WIDTH-1:0] min_reading;
   logic signed [AVG_W-1:0]        average_q8;
   logic [SPIKE_W-1:0]             peak_spike;
   logic [STATUS_W-1:0]            status;
   logic [OUT_CNT_W-1:0]           sample_count;
   logic                           count_overflow;
   modport source(output valid, max_reading, min_reading, average_q8, peak_spike,
                  status, sample_count, count_overflow, input ready);
   modport sink(input valid, max_reading, min_reading, average_q8, peak_spike,
                status, sample_count, count_overflow, output ready);
endinterface

/* hdl/swss_front.sv */
// Front end: unless the queue is full, takes one sample a cycle and keeps the
// window's running stats; the last sample pushes a record. Depends on swss_pkg.
module swss_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic signed [swss_pkg::SAMPLE_WIDTH-1:0] in_sample,
   input  logic                                     in_last,
   input  logic                                     q_full,
   output logic                                     q_push,
   output swss_pkg::swss_rec_type                   q_rec
);
   import swss_pkg::*;

   logic signed [SAMPLE_WIDTH-1:0] max_ff, max_in, min_ff, min_in, prev_ff;
   logic signed [SUM_W-1:0]        sum_ff, sum_in;
   logic [SPIKE_W-1:0]             spike_ff, spike_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic                           ovf_ff, ovf_in;

   logic                           accept, first, saturated;
   logic signed [SAMPLE_WIDTH:0]   diff;
   logic [SAMPLE_WIDTH:0]          mag;
   logic [SPIKE_W-1:0]             mag_clip;
   logic signed [SUM_W:0]          sum_wide;

   assign in_ready  = !q_full;
   assign accept    = in_valid && in_ready;
   assign first     = (count_ff == '0);
   assign saturated = (count_ff >= CNT_W'(MAX_COUNT));

   always_comb begin
      diff     = {in_sample[SAMPLE_WIDTH-1], in_sample} - {prev_ff[SAMPLE_WIDTH-1], prev_ff};
      mag      = diff[SAMPLE_WIDTH] ? (SAMPLE_WIDTH+1)'(0) - diff : diff;
      mag_clip = mag[SAMPLE_WIDTH] ? '1 : mag[SPIKE_W-1:0];
      sum_wide = {sum_ff[SUM_W-1], sum_ff}
               + {{(SUM_W + 1 - SAMPLE_WIDTH){in_sample[SAMPLE_WIDTH-1]}}, in_sample};

      if (first) begin
         max_in   = in_sample;
         min_in   = in_sample;
         spike_in = spike_ff;
      end else begin
         max_in   = (in_sample > max_ff) ? in_sample : max_ff;
         min_in   = (in_sample < min_ff) ? in_sample : min_ff;
         spike_in = (mag_clip > spike_ff) ? mag_clip : spike_ff;
      end

      if (saturated) begin
         sum_in   = sum_ff;
         count_in = count_ff;
         ovf_in   = 1'b1;
      end else begin
         // clamp to the signed sum range
         if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
         else
            sum_in = sum_wide[SUM_W-1:0];
         count_in = count_ff + 1'b1;
         ovf_in   = ovf_ff;
      end

      q_rec.max_reading = max_in;
      q_rec.min_reading = min_in;
      q_rec.sum         = sum_in;
      q_rec.spike       = spike_in;
      q_rec.count       = count_in;
      q_rec.overflow    = ovf_in;
   end

   assign q_push = accept && in_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= '0;
         min_ff   <= '0;
         sum_ff   <= '0;
         prev_ff  <= '0;
         spike_ff <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         if (in_last) begin
            max_ff   <= '0;
            min_ff   <= '0;
            sum_ff   <= '0;
            prev_ff  <= '0;
            spike_ff <= '0;
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            max_ff   <= max_in;
            min_ff   <= min_in;
            sum_ff   <= sum_in;
            prev_ff  <= in_sample;
            spike_ff <= spike_in;
            count_ff <= count_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

endmodule

/* hdl/swss_queue.sv */
// Short register queue of finished window records between front and back.
// Depends on swss_pkg.
module swss_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  swss_pkg::swss_rec_type push_rec,
   output logic                   full,
   input  logic                   pop,
   output logic                   not_empty,
   output swss_pkg::swss_rec_type pop_rec
);
   import swss_pkg::*;

   swss_rec_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  fill_ff, fill_in;
   logic               do_push, do_pop;

   assign full      = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_rec   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         fill_in = fill_ff + 1'b1;
      else if (do_pop && !do_push)
         fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

/* hdl/swss_back.sv */
// Back end: pops a window record, divides sum*256 by the count one quotient
// bit a cycle, grades the spike and holds the report. Depends on swss_pkg.
module swss_back (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_en,
   input  logic [swss_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [swss_pkg::CSR_DATA_W-1:0]          csr_wdata,
   input  logic                                     q_not_empty,
   input  swss_pkg::swss_rec_type                   q_rec,
   output logic                                     q_pop,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic signed [swss_pkg::SAMPLE_WIDTH-1:0] out_max,
   output logic signed [swss_pkg::SAMPLE_WIDTH-1:0] out_min,
   output logic signed [swss_pkg::AVG_W-1:0]        out_avg,
   output logic [swss_pkg::SPIKE_W-1:0]             out_spike,
   output logic [swss_pkg::STATUS_W-1:0]            out_status,
   output logic [swss_pkg::OUT_CNT_W-1:0]           out_count,
   output logic                                     out_overflow
);
   import swss_pkg::*;

   swss_back_state_type state_ff, state_in;
   logic [LIMIT_W-1:0]  stable_ff, critical_ff;
   swss_rec_type        rec_ff;
   logic                neg_ff;
   logic [DIVD_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [ITER_W-1:0]   iter_ff;
   logic                out_valid_ff, load_out;

   logic [SUM_W-1:0]    sum_mag;
   logic [CNT_W:0]      trial, trial_diff;
   logic [DIVD_W-1:0]   signed_quo;
   logic [CNT_W+OUT_CNT_W-1:0] count_wide;
   logic [STATUS_W-1:0] status_grade;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff   <= STABLE_LIMIT_RESET;
         critical_ff <= CRITICAL_LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_STABLE_LIMIT:   stable_ff   <= csr_wdata[LIMIT_W-1:0];
            REG_CRITICAL_LIMIT: critical_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // restoring division step on the magnitude
   always_comb begin
      trial      = {rem_ff, quo_ff[DIVD_W-1]};
      trial_diff = trial - {1'b0, rec_ff.count};
      if (!trial_diff[CNT_W]) begin
         rem_in = trial_diff[CNT_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
      end else begin
         rem_in = trial[CNT_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
      end
   end

   assign sum_mag    = q_rec.sum[SUM_W-1] ? SUM_W'(0) - q_rec.sum : q_rec.sum;
   assign signed_quo = neg_ff ? DIVD_W'(0) - quo_ff : quo_ff;
   assign count_wide = {{OUT_CNT_W{1'b0}}, rec_ff.count};

   always_comb begin
      priority if (rec_ff.spike >= critical_ff) status_grade = STATUS_CRITICAL;
      else if (rec_ff.spike > stable_ff)       status_grade = STATUS_WARNING;
      else                                      status_grade = STATUS_STABLE;
   end

   assign load_out = (state_ff == B_DONE) && (!out_valid_ff || out_ready);
   assign q_pop    = (state_ff == B_IDLE) && q_not_empty;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (q_not_empty) state_in = B_DIV;
         B_DIV:  if (iter_ff == '0) state_in = B_DONE;
         B_DONE: if (load_out) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out)
            out_valid_ff <= 1'b1;
         else if (out_ready)
            out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rec_ff  <= q_rec;
         neg_ff  <= q_rec.sum[SUM_W-1];
         quo_ff  <= {sum_mag, {FRAC_BITS{1'b0}}};
         rem_ff  <= '0;
         iter_ff <= ITER_W'(DIVD_W - 1);
      end else if (state_ff == B_DIV) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         iter_ff <= iter_ff - 1'b1;
      end
      if (load_out) begin
         out_max      <= rec_ff.max_reading;
         out_min      <= rec_ff.min_reading;
         out_avg      <= signed_quo[AVG_W-1:0];
         out_spike    <= rec_ff.spike;
         out_status   <= status_grade;
         out_count    <= count_wide[OUT_CNT_W-1:0];
         out_overflow <= rec_ff.overflow;
      end
   end

   assign out_valid = out_valid_ff;

endmodule

/* hdl/sensor_window_stability_stats_unit.sv */
// Sensor window statistics: top level joining front end, queue and back end.
// Depends on swss_pkg, swss_req_if, swss_rsp_if, swss_front, swss_queue, swss_back.
//
// req_chan carries one signed sample word per handshake, with last_sample set on
// the final word of a window. rsp_chan returns one report word per window: max,
// min, average (Q8, truncated toward zero), largest spike, status, count and
// overflow flag. Limits are written through csr_write_en/csr_index/csr_wdata
// while the block is idle: index 0 stable limit, index 1 critical limit.
// Throughput: one sample word per cycle while the queue is not full. After its
// last word is taken, a window's record is popped from the queue, run through
// the bit-serial divider and loaded into the output register that drives
// rsp_chan; the divider serves one report at a time, so back-to-back short
// windows fill the two-entry queue and drop req_chan.ready.
// The report register holds while rsp_chan.ready is low; the divider can
// finish the next window underneath it, then stalls, and the front keeps
// taking samples until the queue fills.
// Reset (synchronous, active high) clears the window, the queue and the report
// valid flag and returns the limits to 3 and 7.
module sensor_window_stability_stats_unit (
   input  logic                            clock,
   input  logic                            reset,
   swss_req_if.sink                        req_chan,
   swss_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_en,
   input  logic [swss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [swss_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import swss_pkg::*;

   logic         q_full, q_push, q_pop, q_not_empty;
   swss_rec_type push_rec, pop_rec;

   swss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_sample (req_chan.sample),
      .in_last   (req_chan.last_sample),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_rec     (push_rec)
   );

   swss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_rec  (push_rec),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_rec   (pop_rec)
   );

   swss_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_not_empty  (q_not_empty),
      .q_rec        (pop_rec),
      .q_pop        (q_pop),
      .out_valid    (rsp_chan.valid),
      .out_ready    (rsp_chan.ready),
      .out_max      (rsp_chan.max_reading),
      .out_min      (rsp_chan.min_reading),
      .out_avg      (rsp_chan.average_q8),
      .out_spike    (rsp_chan.peak_spike),
      .out_status   (rsp_chan.status),
      .out_count    (rsp_chan.sample_count),
      .out_overflow (rsp_chan.count_overflow)
   );

endmodule

/* hdl/swss_checker.sv */
// Port-level checks on the report channel, bound to the top level.
// Depends on swss_pkg and sensor_window_stability_stats_unit.
module swss_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   input  logic signed [swss_pkg::SAMPLE_WIDTH-1:0] max_reading,
   input  logic signed [swss_pkg::SAMPLE_WIDTH-1:0] min_reading,
   input  logic signed [swss_pkg::AVG_W-1:0]        average_q8,
   input  logic [swss_pkg::OUT_CNT_W-1:0]           sample_count,
   input  logic                                     count_overflow
);
   import swss_pkg::*;

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("report word dropped while stalled");

   a_word_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(average_q8) && $stable(max_reading))
      else $error("report word changed while stalled");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> min_reading <= max_reading)
      else $error("min above max in report");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> sample_count != '0)
      else $error("report with empty window");

   a_overflow_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && count_overflow |-> sample_count == OUT_CNT_W'(MAX_COUNT))
      else $error("overflow flagged below saturated count");

endmodule

bind sensor_window_stability_stats_unit swss_checker u_swss_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .max_reading    (rsp_chan.max_reading),
   .min_reading    (rsp_chan.min_reading),
   .average_q8     (rsp_chan.average_q8),
   .sample_count   (rsp_chan.sample_count),
   .count_overflow (rsp_chan.count_overflow)
);

/* test/sensor_window_stability_stats_unit_test.sv */
// Self-checking testbench for sensor_window_stability_stats_unit: random sample windows
// with stalls on both channels, reports checked against an in-bench window predictor.
// Depends on swss_pkg, swss_req_if, swss_rsp_if and the block itself.
module sensor_window_stability_stats_unit_test;
   import swss_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           last_sample;
   } sample_word_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] max_reading;
      logic signed [SAMPLE_WIDTH-1:0] min_reading;
      logic signed [AVG_W-1:0]        average_q8;
      logic [SPIKE_W-1:0]             peak_spike;
      logic [STATUS_W-1:0]            status;
      logic [OUT_CNT_W-1:0]           sample_count;
      logic                           count_overflow;
   } window_report_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   swss_req_if req_chan();
   swss_rsp_if rsp_chan();

   sensor_window_stability_stats_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   sample_word_type   pending_samples[$];
   window_report_type expected_reports[$];

   // predictor copy of limits and window state
   logic [LIMIT_W-1:0] stable_limit;
   logic [LIMIT_W-1:0] critical_limit;
   int                 win_max;
   int                 win_min;
   int                 win_sum;
   int                 win_prev;
   int                 win_spike;
   int                 win_count;
   bit                 win_overflow;

   bit req_took;
   bit calm;
   int req_gap;
   int rsp_gap;
   int mismatches;
   int samples_taken;
   int reports_seen;
   int overflow_reports;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic fold_sample(input int s, input bit last);
      window_report_type rep;
      longint            avg;
      int                mag;
      begin
         if (win_count == 0) begin
            win_max = s;
            win_min = s;
         end else begin
            if (s > win_max) win_max = s;
            if (s < win_min) win_min = s;
            mag = (s > win_prev) ? s - win_prev : win_prev - s;
            if (mag > 4095) mag = 4095;
            if (mag > win_spike) win_spike = mag;
         end
         win_prev = s;
         if (win_count >= MAX_COUNT) begin
            win_overflow = 1'b1;
         end else begin
            win_sum = win_sum + s;
            if (win_sum > 524287) win_sum = 524287;
            if (win_sum < -524288) win_sum = -524288;
            win_count++;
         end
         if (last) begin
            avg = (longint'(win_sum) * 256) / longint'(win_count);   // truncates toward zero
            rep.max_reading    = win_max[SAMPLE_WIDTH-1:0];
            rep.min_reading    = win_min[SAMPLE_WIDTH-1:0];
            rep.average_q8     = avg[AVG_W-1:0];
            rep.peak_spike     = win_spike[SPIKE_W-1:0];
            if (win_spike >= critical_limit)
               rep.status = STATUS_CRITICAL;
            else if (win_spike > stable_limit)
               rep.status = STATUS_WARNING;
            else
               rep.status = STATUS_STABLE;
            rep.sample_count   = win_count[OUT_CNT_W-1:0];
            rep.count_overflow = win_overflow;
            expected_reports.push_back(rep);
            win_max = 0;
            win_min = 0;
            win_sum = 0;
            win_prev = 0;
            win_spike = 0;
            win_count = 0;
            win_overflow = 1'b0;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      begin
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      end
   endtask

   // sample side: prediction on every accepted word
   always @(posedge clock) begin
      req_took <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         samples_taken++;
         fold_sample(int'(req_chan.sample), req_chan.last_sample);
      end
   end

   // report side: compare against the oldest prediction
   always @(posedge clock) begin
      window_report_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         reports_seen++;
         if (expected_reports.size() == 0) begin
            $error("report word with no window outstanding");
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            if (want.count_overflow) overflow_reports++;
            check_field("max_reading", 32'(want.max_reading), 32'(rsp_chan.max_reading));
            check_field("min_reading", 32'(want.min_reading), 32'(rsp_chan.min_reading));
            check_field("average_q8", 32'(want.average_q8), 32'(rsp_chan.average_q8));
            check_field("peak_spike", 32'(want.peak_spike), 32'(rsp_chan.peak_spike));
            check_field("status", 32'(want.status), 32'(rsp_chan.status));
            check_field("sample_count", 32'(want.sample_count), 32'(rsp_chan.sample_count));
            check_field("count_overflow", 32'(want.count_overflow),
                        32'(rsp_chan.count_overflow));
         end
      end
   end

   // sample driver
   always @(negedge clock) begin
      sample_word_type w;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_took) begin
         if (req_gap > 0) begin
            req_gap--;
            req_chan.valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            req_gap = $urandom_range(1, 9) - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            w = pending_samples.pop_front();
            req_chan.valid       <= 1'b1;
            req_chan.sample      <= w.sample;
            req_chan.last_sample <= w.last_sample;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // report sink with back-pressure bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         rsp_gap = $urandom_range(1, 9) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic push_word(input int s, input bit last);
      sample_word_type w;
      begin
         w.sample      = s[SAMPLE_WIDTH-1:0];
         w.last_sample = last;
         pending_samples.push_back(w);
      end
   endtask

   // random windows until about n words are queued; every window is closed
   task automatic queue_windows(input int n);
      int queued;
      int len;
      int mode;
      int walk;
      int step;
      int s;
      begin
         queued = 0;
         while (queued < n) begin
            case ($urandom_range(0, 9))
               0:       len = $urandom_range(126, 140);   // around the count ceiling
               1, 2:    len = $urandom_range(13, 60);
               default: len = $urandom_range(1, 12);
            endcase
            mode = $urandom_range(0, 3);
            walk = int'($urandom_range(0, 4095)) - 2048;
            step = $urandom_range(0, 12);
            for (int i = 0; i < len; i++) begin
               case (mode)
                  0: s = int'($urandom_range(0, 4095)) - 2048;
                  1: begin
                     case ($urandom_range(0, 5))
                        0: s = -2048;
                        1: s = 2047;
                        2: s = 0;
                        3: s = -1;
                        4: s = 1;
                        default: s = -2047;
                     endcase
                  end
                  default: begin
                     // slow drift, keeps spikes near the limits
                     walk = walk + int'($urandom_range(0, 2 * step)) - step;
                     if (walk > 2047) walk = 2047;
                     if (walk < -2048) walk = -2048;
                     s = walk;
                  end
               endcase
               push_word(s, i == len - 1);
            end
            queued += len;
         end
      end
   endtask

   task automatic drain;
      begin
         while (pending_samples.size() != 0 || req_chan.valid || expected_reports.size() != 0)
            @(posedge clock);
         repeat (40) @(posedge clock);
      end
   endtask

   task automatic set_limits(input logic [LIMIT_W-1:0] stable, input logic [LIMIT_W-1:0] crit);
      begin
         @(negedge clock);
         csr_write_en = 1'b1;
         csr_index    = REG_STABLE_LIMIT;
         csr_wdata    = stable;
         @(negedge clock);
         csr_index    = REG_CRITICAL_LIMIT;
         csr_wdata    = crit;
         @(negedge clock);
         csr_write_en = 1'b0;
         stable_limit   = stable;
         critical_limit = crit;
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = REG_STABLE_LIMIT;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.sample = '0;
      req_chan.last_sample = 1'b0;
      rsp_chan.ready = 1'b0;
      req_took = 1'b0;
      calm = 1'b0;
      req_gap = 0;
      rsp_gap = 0;
      mismatches = 0;
      samples_taken = 0;
      reports_seen = 0;
      overflow_reports = 0;
      stable_limit = STABLE_LIMIT_RESET;
      critical_limit = CRITICAL_LIMIT_RESET;
      win_max = 0;
      win_min = 0;
      win_sum = 0;
      win_prev = 0;
      win_spike = 0;
      win_count = 0;
      win_overflow = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed windows on the reset limits
      push_word(0, 0);     push_word(3, 1);       // spike on the stable limit
      push_word(0, 0);     push_word(4, 1);       // just above: warning
      push_word(0, 0);     push_word(7, 1);       // on the critical limit
      push_word(2047, 1);                         // single-word windows
      push_word(-2048, 1);
      push_word(2047, 0);  push_word(-2048, 1);   // full-scale spike
      push_word(-1, 0);    push_word(0, 0);  push_word(0, 1);   // negative average truncates
      push_word(1, 0);     push_word(1, 0);  push_word(-1, 1);
      drain();

      set_limits(12'd0, 12'd0);
      queue_windows(220);
      drain();
      set_limits(12'd4095, 12'd4095);
      queue_windows(220);
      drain();
      set_limits(12'd10, 12'd5);                  // overlapping limits
      queue_windows(220);
      drain();
      set_limits(12'd0, 12'd4095);
      queue_windows(220);
      drain();
      for (int p = 0; p < 3; p++) begin
         if ($urandom_range(0, 3) == 0)
            set_limits(LIMIT_W'($urandom_range(0, 4095)), LIMIT_W'($urandom_range(0, 4095)));
         else
            set_limits(LIMIT_W'($urandom_range(0, 40)), LIMIT_W'($urandom_range(0, 60)));
         queue_windows(120);
         drain();
      end
      // closing stretch at full rate on both sides
      calm = 1'b1;
      set_limits(LIMIT_W'($urandom_range(0, 20)), LIMIT_W'($urandom_range(5, 40)));
      queue_windows(300);
      drain();

      $display("%0d sample words in %0d window reports, %0d of them over the count ceiling",
               samples_taken, reports_seen, overflow_reports);
      if (mismatches == 0)
         $display("sensor_window_stability_stats_unit: match");
      else
         $display("sensor_window_stability_stats_unit: mismatch");
      $finish;
   end

   initial begin
      #20000000;
      $display("sensor_window_stability_stats_unit: mismatch");
      $finish;
   end

endmodule
